### hdl/assert_macros.svh
// Assertion helpers for the RTL; byte_set_statistics_unit.sv includes them.
// ASSERT_RST is disabled while the reset is asserted; ASSERT_ALWAYS also checks during reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_RST(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define ASSERT_RST(lbl, clk, rst_n, prop, msg)
`define ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif
`endif

### hdl/bss_pkg.sv
`default_nettype none

package bss_pkg;

  // Sample and result widths
  localparam int unsigned ValueW  = 8;
  localparam int unsigned MedianW = 9;

  // Sequencer states
  typedef enum logic [1:0] {
    ST_LOAD,
    ST_SCAN,
    ST_DECIDE,
    ST_FINISH
  } state_e;

  // One result word
  typedef struct packed {
    logic [MedianW-1:0] median_doubled;
    logic [ValueW-1:0]  mean;
    logic [ValueW-1:0]  minimum;
    logic [ValueW-1:0]  maximum;
  } result_t;

endpackage

`default_nettype wire

### hdl/byte_set_statistics_unit.sv
`default_nettype none

// Byte set statistics: takes one unsigned byte per word on the slave stream, with tlast on
// the final sample of a set, and gives one result word per set (maximum, minimum, mean
// rounded down, median times two, and an overflow flag in tuser when samples beyond
// CAPACITY were dropped). Loading takes one sample per cycle. After the closing word the
// input stalls while the median is found by a bit-by-bit value search: each of the 16
// passes (eight bits for each of the two middle values) reads all n stored samples through
// the single read port of the sample memory and counts those below a candidate in one
// shared compare unit. The mean comes from an eight-step divider that runs alongside.
// The next set may be loaded while the previous result still waits on the master side.
module byte_set_statistics_unit #(
  parameter int unsigned CAPACITY = 64
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [7:0]  s_axis_tdata,   // [7:0] value
  input  wire logic        s_axis_tlast,   // last
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [39:0]      m_axis_tdata,   // [7:0] maximum, [15:8] minimum, [23:16] mean,
                                           // [32:24] median_doubled, rest zero
  output logic             m_axis_tuser    // overflow
);

`include "assert_macros.svh"

  localparam int unsigned CW = $clog2(CAPACITY + 1);
  localparam int unsigned AW = $clog2(CAPACITY);
  localparam int unsigned SW = bss_pkg::ValueW + CW;
  localparam int unsigned VW = bss_pkg::ValueW;
  localparam int unsigned BW = $clog2(VW);

  bss_pkg::state_e state_q, state_d;

  logic [CW-1:0]  cnt_q, cnt_d;
  logic [SW-1:0]  sum_q, sum_d;
  logic           drop_q, drop_d;
  logic [VW-1:0]  max_q, max_d, min_q, min_d;

  logic [BW-1:0]  bit_q, bit_d;
  logic           sel_q, sel_d;
  logic [VW-1:0]  r_q, r_d, r0_q, r0_d;
  logic [CW-1:0]  lt_q, lt_d;
  logic [AW-1:0]  addr_q, addr_d;
  logic           issue_done_q, issue_done_d;
  logic           rd_vld_q, rd_last_q;

  logic           m_valid_q, m_valid_d;
  bss_pkg::result_t res_q, res_d;
  logic           ovf_q, ovf_d;

  logic           in_fire, full, store, close_set, rd_en, last_addr, div_done;
  logic [VW-1:0]  cand, rd_data, mean;
  logic [CW-1:0]  k_sel;

  assign s_axis_tready = (state_q == bss_pkg::ST_LOAD);
  assign in_fire       = s_axis_tvalid && s_axis_tready;
  assign full          = (cnt_q == CW'(CAPACITY));
  assign store         = in_fire && !full;
  assign close_set     = in_fire && s_axis_tlast;

  // Candidate and rank for the value search
  assign cand      = r_q | (VW'(1) << bit_q);
  assign k_sel     = sel_q ? (cnt_q >> 1) : ((cnt_q - CW'(1)) >> 1);
  assign rd_en     = (state_q == bss_pkg::ST_SCAN) && !issue_done_q;
  assign last_addr = (CW'(addr_q) == (cnt_q - CW'(1)));

  bss_mem #(
    .DEPTH (CAPACITY),
    .AW    (AW)
  ) u_mem (
    .clk_i     (clk_i),
    .wr_en_i   (store),
    .wr_addr_i (cnt_q[AW-1:0]),
    .wr_data_i (s_axis_tdata),
    .rd_en_i   (rd_en),
    .rd_addr_i (addr_q),
    .rd_data_o (rd_data)
  );

  bss_div #(
    .SW (SW),
    .CW (CW)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (close_set),
    .dividend_i (sum_d),
    .divisor_i  (cnt_d),
    .done_o     (div_done),
    .quotient_o (mean)
  );

  // Sequencer: load, scan passes with a decision after each, final write of the result word
  always_comb begin
    state_d      = state_q;
    cnt_d        = cnt_q;
    sum_d        = sum_q;
    drop_d       = drop_q;
    max_d        = max_q;
    min_d        = min_q;
    bit_d        = bit_q;
    sel_d        = sel_q;
    r_d          = r_q;
    r0_d         = r0_q;
    lt_d         = lt_q;
    addr_d       = addr_q;
    issue_done_d = issue_done_q;
    m_valid_d    = m_valid_q;
    res_d        = res_q;
    ovf_d        = ovf_q;

    // Release the result word once taken
    if (m_valid_q && m_axis_tready) begin
      m_valid_d = 1'b0;
    end

    // Count samples below the candidate as read data returns
    if (rd_vld_q && (rd_data < cand)) begin
      lt_d = lt_q + CW'(1);
    end

    unique case (state_q)
      bss_pkg::ST_LOAD: begin
        if (store) begin
          cnt_d = cnt_q + CW'(1);
          sum_d = sum_q + SW'(s_axis_tdata);
          if (cnt_q == '0) begin
            max_d = s_axis_tdata;
            min_d = s_axis_tdata;
          end else begin
            if (s_axis_tdata > max_q) max_d = s_axis_tdata;
            if (s_axis_tdata < min_q) min_d = s_axis_tdata;
          end
        end else if (in_fire) begin
          drop_d = 1'b1;
        end
        if (close_set) begin
          bit_d        = BW'(VW - 1);
          sel_d        = 1'b0;
          r_d          = '0;
          lt_d         = '0;
          addr_d       = '0;
          issue_done_d = 1'b0;
          state_d      = bss_pkg::ST_SCAN;
        end
      end
      bss_pkg::ST_SCAN: begin
        if (rd_en) begin
          if (last_addr) begin
            issue_done_d = 1'b1;
          end else begin
            addr_d = addr_q + AW'(1);
          end
        end
        if (rd_vld_q && rd_last_q) begin
          state_d = bss_pkg::ST_DECIDE;
        end
      end
      bss_pkg::ST_DECIDE: begin
        // Keep the candidate bit while no more than k samples lie below it
        lt_d         = '0;
        addr_d       = '0;
        issue_done_d = 1'b0;
        if (lt_q <= k_sel) begin
          r_d = cand;
        end
        if (bit_q == '0) begin
          if (sel_q) begin
            state_d = bss_pkg::ST_FINISH;
          end else begin
            r0_d    = (lt_q <= k_sel) ? cand : r_q;
            r_d     = '0;
            sel_d   = 1'b1;
            bit_d   = BW'(VW - 1);
            state_d = bss_pkg::ST_SCAN;
          end
        end else begin
          bit_d   = bit_q - BW'(1);
          state_d = bss_pkg::ST_SCAN;
        end
      end
      bss_pkg::ST_FINISH: begin
        // Write the result word when the output register is free and the mean is ready, then start a new set
        if ((!m_valid_q || m_axis_tready) && div_done) begin
          res_d.maximum        = max_q;
          res_d.minimum        = min_q;
          res_d.mean           = mean;
          res_d.median_doubled = bss_pkg::MedianW'(r0_q) + bss_pkg::MedianW'(r_q);
          ovf_d                = drop_q;
          m_valid_d            = 1'b1;
          cnt_d                = '0;
          sum_d                = '0;
          drop_d               = 1'b0;
          state_d              = bss_pkg::ST_LOAD;
        end
      end
      default: state_d = bss_pkg::ST_LOAD;
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= bss_pkg::ST_LOAD;
      cnt_q        <= '0;
      sum_q        <= '0;
      drop_q       <= 1'b0;
      bit_q        <= '0;
      sel_q        <= 1'b0;
      lt_q         <= '0;
      addr_q       <= '0;
      issue_done_q <= 1'b0;
      rd_vld_q     <= 1'b0;
      rd_last_q    <= 1'b0;
      m_valid_q    <= 1'b0;
    end else begin
      state_q      <= state_d;
      cnt_q        <= cnt_d;
      sum_q        <= sum_d;
      drop_q       <= drop_d;
      bit_q        <= bit_d;
      sel_q        <= sel_d;
      lt_q         <= lt_d;
      addr_q       <= addr_d;
      issue_done_q <= issue_done_d;
      rd_vld_q     <= rd_en;
      rd_last_q    <= rd_en && last_addr;
      m_valid_q    <= m_valid_d;
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    max_q <= max_d;
    min_q <= min_d;
    r_q   <= r_d;
    r0_q  <= r0_d;
    res_q <= res_d;
    ovf_q <= ovf_d;
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = 40'(res_q);
  assign m_axis_tuser  = ovf_q;

  `ASSERT_RST(a_cnt_cap, clk_i, rst_ni, cnt_q <= CW'(CAPACITY), "sample count beyond capacity")
  `ASSERT_RST(a_lt_cnt, clk_i, rst_ni, (state_q == bss_pkg::ST_DECIDE) |-> (lt_q <= cnt_q), "below-count exceeds sample count")
  `ASSERT_RST(a_rd_scan, clk_i, rst_ni, rd_vld_q |-> ($past(state_q) == bss_pkg::ST_SCAN), "read data outside a scan pass")
  `ASSERT_RST(a_out_src, clk_i, rst_ni, $rose(m_valid_q) |-> (($past(state_q) == bss_pkg::ST_FINISH) && $past(div_done)), "result word written before the mean was ready")

endmodule

`default_nettype wire

### hdl/bss_mem.sv
`default_nettype none

module bss_mem #(
  parameter int unsigned DEPTH = 64,
  parameter int unsigned AW    = 6
) (
  input  wire logic                           clk_i,
  input  wire logic                           wr_en_i,
  input  wire logic [AW-1:0]                  wr_addr_i,
  input  wire logic [bss_pkg::ValueW-1:0]     wr_data_i,
  input  wire logic                           rd_en_i,
  input  wire logic [AW-1:0]                  rd_addr_i,
  output logic      [bss_pkg::ValueW-1:0]     rd_data_o
);

  logic [bss_pkg::ValueW-1:0] mem_q [DEPTH];

  // Write one sample
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  // Registered read
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_o <= mem_q[rd_addr_i];
    end
  end

endmodule

`default_nettype wire

### hdl/bss_div.sv
`default_nettype none

module bss_div #(
  parameter int unsigned SW = 15,
  parameter int unsigned CW = 7
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       start_i,
  input  wire logic [SW-1:0]              dividend_i,
  input  wire logic [CW-1:0]              divisor_i,
  output logic                            done_o,
  output logic [bss_pkg::ValueW-1:0]      quotient_o
);

  localparam int unsigned QW = bss_pkg::ValueW;

  logic [SW-1:0]           rem_q, rem_d;
  logic [SW-1:0]           den_q, den_d;
  logic [QW-1:0]           quo_q, quo_d;
  logic [$clog2(QW)-1:0]   step_q, step_d;
  logic                    busy_q, busy_d;
  logic                    done_q, done_d;
  logic                    ge;

  // One restoring step a cycle: the quotient fits in a byte, so start at bit 7
  always_comb begin
    rem_d  = rem_q;
    den_d  = den_q;
    quo_d  = quo_q;
    step_d = step_q;
    busy_d = busy_q;
    done_d = done_q;
    ge     = (rem_q >= den_q);
    if (start_i) begin
      rem_d  = dividend_i;
      den_d  = SW'({divisor_i, {(QW-1){1'b0}}});
      quo_d  = '0;
      step_d = ($clog2(QW))'(QW - 1);
      busy_d = 1'b1;
      done_d = 1'b0;
    end else if (busy_q) begin
      if (ge) begin
        rem_d = rem_q - den_q;
      end
      quo_d = {quo_q[QW-2:0], ge};
      den_d = den_q >> 1;
      if (step_q == '0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end else begin
        step_d = step_q - 1'b1;
      end
    end
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      step_q <= step_d;
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    den_q <= den_d;
    quo_q <= quo_d;
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule

`default_nettype wire
